/* rtl/core/turtle_bitmap_plotter_defines.svh */
// Assertion macros shared by the plotter's checker.
`ifndef TURTLE_BITMAP_PLOTTER_DEFINES_SVH
`define TURTLE_BITMAP_PLOTTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TBP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/tbp_pkg.sv */
// Package with the plotter's shared types and constants.
`default_nettype none

package tbp_pkg;

	// Field widths fixed by the channel payloads.
	localparam int MODE_W     = 3;
	localparam int STEPS_W    = 8;
	localparam int COORD_W    = 6;
	localparam int ROW_BITS_W = 64;

	// Home cell of the turtle on both axes, before clamping to the grid.
	localparam int START_CELL = 10;

	typedef enum logic [MODE_W-1:0] {
		MODE_PEN_UP   = 3'd0,
		MODE_PEN_DOWN = 3'd1,
		MODE_TURN_R   = 3'd2,
		MODE_TURN_L   = 3'd3,
		MODE_MOVE     = 3'd4,
		MODE_DUMP     = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		HEAD_UP    = 2'd0,
		HEAD_RIGHT = 2'd1,
		HEAD_DOWN  = 2'd2,
		HEAD_LEFT  = 2'd3
	} heading_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOVE,
		ST_DUMP
	} state_t;

	// One access to the bitmap memory.
	typedef struct packed {
		logic               en;
		logic [COORD_W-1:0] row;
	} mem_req_t;

endpackage

`default_nettype wire

/* rtl/core/tbp_if.sv */
// Handshake interfaces for the command and the row dump channels.
`default_nettype none

interface tbp_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [tbp_pkg::MODE_W-1:0]   mode;
	logic [tbp_pkg::STEPS_W-1:0]  move_steps;

	modport source (output valid, output mode, output move_steps, input ready);
	modport sink (input valid, input mode, input move_steps, output ready);
endinterface

interface tbp_row_if;
	logic                            valid;
	logic                            ready;
	logic [tbp_pkg::COORD_W-1:0]     row_index;
	logic [tbp_pkg::ROW_BITS_W-1:0]  row_bits;
	logic                            last_row;

	modport source (output valid, output row_index, output row_bits, output last_row,
		input ready);
	modport sink (input valid, input row_index, input row_bits, input last_row,
		output ready);
endinterface

`default_nettype wire

/* rtl/core/turtle_bitmap_plotter.sv */
// Move: the step count is clamped to the cells left to the edge, then one cell a cycle.
// Pen and turn commands update the turtle when accepted; invalid modes are dropped.
// Dump: rows go out through a two-beat buffer, one row a cycle while the receiver keeps up.
// Each marked cell is a read-modify-write on the bitmap memory's read and write ports.
// Reset puts the turtle at home, heading right, pen up, at once; rows read as zero until written.
`default_nettype none

module turtle_bitmap_plotter #(
	parameter int GRID_SIZE = 64
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tbp_cmd_if.sink    cmd,
	tbp_row_if.source  rows
);

	localparam int ROW_W = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
	localparam int START = (tbp_pkg::START_CELL > GRID_SIZE - 1) ?
		GRID_SIZE - 1 : tbp_pkg::START_CELL;
	localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(GRID_SIZE - 1);
	localparam logic [ROW_W-1:0] ROW_START = ROW_W'(START);

	tbp_pkg::state_t   state_q;
	tbp_pkg::state_t   state_d;
	tbp_pkg::heading_t heading_q;
	tbp_pkg::mode_t    cmd_mode;

	logic [ROW_W-1:0]  pos_row_q;
	logic [ROW_W-1:0]  pos_col_q;
	logic              pen_q;
	logic [ROW_W-1:0]  remain_q;
	logic [ROW_W-1:0]  dump_row_q;

	logic              cmd_ready;
	logic              cmd_acc;
	logic [ROW_W-1:0]  edge_dist;
	logic [ROW_W-1:0]  eff_steps;
	logic              dump_issue;
	logic              dump_room;

	tbp_pkg::mem_req_t rd_req;
	tbp_pkg::mem_req_t wr_req;
	logic [GRID_SIZE-1:0] rd_data;
	logic [GRID_SIZE-1:0] wr_data;

	// Mark stage and dump read stage.
	logic              mark_s1;
	logic [ROW_W-1:0]  mark_row_s1;
	logic [ROW_W-1:0]  mark_col_s1;
	logic              rd_pend_s1;
	logic [ROW_W-1:0]  rd_row_s1;
	logic              rd_last_s1;

	// Two-beat output buffer.
	logic [ROW_W-1:0]     ent_row_q  [2];
	logic [GRID_SIZE-1:0] ent_bits_q [2];
	logic                 ent_last_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           cnt_q;
	logic                 pop;
	logic [2:0]           occ_next;

	assign cmd_mode = tbp_pkg::mode_t'(cmd.mode);
	assign cmd.ready = cmd_ready;
	assign cmd_acc  = cmd.valid && cmd_ready;

	// Cells left before the edge in the current heading; steps beyond it are clamped away.
	always_comb begin
		case (heading_q)
			tbp_pkg::HEAD_UP:    edge_dist = pos_row_q;
			tbp_pkg::HEAD_RIGHT: edge_dist = ROW_LAST - pos_col_q;
			tbp_pkg::HEAD_DOWN:  edge_dist = ROW_LAST - pos_row_q;
			default:             edge_dist = pos_col_q;
		endcase
	end

	assign eff_steps = (cmd.move_steps > tbp_pkg::STEPS_W'(edge_dist)) ?
		edge_dist : cmd.move_steps[ROW_W-1:0];

	// Room in the output buffer for one more dump read, counting the one in flight.
	assign pop      = (cnt_q != 2'd0) && rows.ready;
	assign occ_next = {1'b0, cnt_q} + {2'b0, rd_pend_s1} - {2'b0, pop};
	assign dump_room = (occ_next <= 3'd1);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			tbp_pkg::ST_IDLE: begin
				if (cmd_acc && cmd_mode == tbp_pkg::MODE_MOVE) begin
					state_d = tbp_pkg::ST_MOVE;
				end else if (cmd_acc && cmd_mode == tbp_pkg::MODE_DUMP) begin
					state_d = tbp_pkg::ST_DUMP;
				end
			end
			tbp_pkg::ST_MOVE: begin
				if (remain_q == '0) begin
					state_d = tbp_pkg::ST_IDLE;
				end
			end
			tbp_pkg::ST_DUMP: begin
				if (dump_issue && dump_row_q == ROW_LAST) begin
					state_d = tbp_pkg::ST_IDLE;
				end
			end
			default: state_d = tbp_pkg::ST_IDLE;
		endcase
	end

	// State outputs: command ready and the memory read request.
	always_comb begin
		cmd_ready  = 1'b0;
		dump_issue = 1'b0;
		rd_req     = '0;
		case (state_q)
			tbp_pkg::ST_IDLE: begin
				cmd_ready = 1'b1;
			end
			tbp_pkg::ST_MOVE: begin
				rd_req.en  = pen_q;
				rd_req.row = tbp_pkg::COORD_W'(pos_row_q);
			end
			tbp_pkg::ST_DUMP: begin
				dump_issue = dump_room;
				rd_req.en  = dump_room;
				rd_req.row = tbp_pkg::COORD_W'(dump_row_q);
			end
			default: begin
				cmd_ready = 1'b0;
			end
		endcase
	end

	// Turtle state and sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= tbp_pkg::ST_IDLE;
			heading_q  <= tbp_pkg::HEAD_RIGHT;
			pen_q      <= 1'b0;
			pos_row_q  <= ROW_START;
			pos_col_q  <= ROW_START;
			remain_q   <= '0;
			dump_row_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd_acc) begin
				case (cmd_mode)
					tbp_pkg::MODE_PEN_UP:   pen_q <= 1'b0;
					tbp_pkg::MODE_PEN_DOWN: pen_q <= 1'b1;
					tbp_pkg::MODE_TURN_R:
						heading_q <= tbp_pkg::heading_t'(2'(heading_q + 2'd1));
					tbp_pkg::MODE_TURN_L:
						heading_q <= tbp_pkg::heading_t'(2'(heading_q + 2'd3));
					tbp_pkg::MODE_MOVE:     remain_q <= eff_steps;
					tbp_pkg::MODE_DUMP:     dump_row_q <= '0;
					default:                pen_q <= pen_q;
				endcase
			end
			// One cell per cycle; the step count is already clamped to the edge.
			if (state_q == tbp_pkg::ST_MOVE && remain_q != '0) begin
				remain_q <= remain_q - ROW_W'(1);
				case (heading_q)
					tbp_pkg::HEAD_UP:    pos_row_q <= pos_row_q - ROW_W'(1);
					tbp_pkg::HEAD_RIGHT: pos_col_q <= pos_col_q + ROW_W'(1);
					tbp_pkg::HEAD_DOWN:  pos_row_q <= pos_row_q + ROW_W'(1);
					default:             pos_col_q <= pos_col_q - ROW_W'(1);
				endcase
			end
			if (dump_issue) begin
				dump_row_q <= dump_row_q + ROW_W'(1);
			end
		end
	end

	// Stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_s1    <= 1'b0;
			rd_pend_s1 <= 1'b0;
		end else begin
			mark_s1    <= (state_q == tbp_pkg::ST_MOVE) && pen_q;
			rd_pend_s1 <= dump_issue;
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		mark_row_s1 <= pos_row_q;
		mark_col_s1 <= pos_col_q;
		rd_row_s1   <= dump_row_q;
		rd_last_s1  <= (dump_row_q == ROW_LAST);
	end

	// Write back the row with the visited cell set.
	assign wr_req.en  = mark_s1;
	assign wr_req.row = tbp_pkg::COORD_W'(mark_row_s1);
	assign wr_data    = rd_data | (GRID_SIZE'(1) << mark_col_s1);

	tbp_bitmap #(
		.GRID_SIZE(GRID_SIZE)
	) u_bitmap (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_req  (rd_req),
		.rd_data (rd_data),
		.wr_req  (wr_req),
		.wr_data (wr_data)
	);

	// Output buffer pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (rd_pend_s1) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, rd_pend_s1} - {1'b0, pop};
		end
	end

	// Output buffer entries.
	always_ff @(posedge clk) begin
		if (rd_pend_s1) begin
			ent_row_q[wr_ptr_q]  <= rd_row_s1;
			ent_bits_q[wr_ptr_q] <= rd_data;
			ent_last_q[wr_ptr_q] <= rd_last_s1;
		end
	end

	assign rows.valid     = (cnt_q != 2'd0);
	assign rows.row_index = tbp_pkg::COORD_W'(ent_row_q[rd_ptr_q]);
	assign rows.row_bits  = tbp_pkg::ROW_BITS_W'(ent_bits_q[rd_ptr_q]);
	assign rows.last_row  = ent_last_q[rd_ptr_q];

endmodule

`default_nettype wire

/* rtl/core/tbp_bitmap.sv */
// Bitmap row memory with per-row valid flags and write-to-read forwarding.
`default_nettype none

module tbp_bitmap #(
	parameter int GRID_SIZE = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire tbp_pkg::mem_req_t    rd_req,
	output logic [GRID_SIZE-1:0]      rd_data,
	input  wire tbp_pkg::mem_req_t    wr_req,
	input  wire logic [GRID_SIZE-1:0] wr_data
);

	localparam int ROW_W = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;

	logic [GRID_SIZE-1:0] mem_q [GRID_SIZE];
	logic [GRID_SIZE-1:0] row_valid_q;
	logic [GRID_SIZE-1:0] mem_rd_s1;
	logic [GRID_SIZE-1:0] fwd_data_s1;
	logic                 hit_s1;
	logic                 fwd_s1;
	logic [ROW_W-1:0]     rd_row;
	logic [ROW_W-1:0]     wr_row;

	assign rd_row = rd_req.row[ROW_W-1:0];
	assign wr_row = wr_req.row[ROW_W-1:0];

	// Synchronous memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_req.en) begin
			mem_q[wr_row] <= wr_data;
		end
		if (rd_req.en) begin
			mem_rd_s1 <= mem_q[rd_row];
		end
		fwd_data_s1 <= wr_data;
	end

	// A row never written since reset reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			hit_s1      <= 1'b0;
			fwd_s1      <= 1'b0;
		end else begin
			if (wr_req.en) begin
				row_valid_q[wr_row] <= 1'b1;
			end
			hit_s1 <= row_valid_q[rd_row];
			fwd_s1 <= wr_req.en && (wr_row == rd_row);
		end
	end

	// A write at the same edge as the read wins over the stale memory word.
	assign rd_data = fwd_s1 ? fwd_data_s1 : (hit_s1 ? mem_rd_s1 : '0);

endmodule

`default_nettype wire

/* rtl/core/tbp_checker.sv */
// Port checker for the plotter's dump channel, bound to the top level.
`default_nettype none
`include "turtle_bitmap_plotter_defines.svh"

module tbp_checker #(
	parameter int GRID_SIZE = 64
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [5:0]  row_index,
	input wire logic [63:0] row_bits,
	input wire logic        last_row
);

	localparam logic [5:0]  ROW_LAST    = 6'(GRID_SIZE - 1);
	localparam logic [63:0] UNUSED_COLS = ~((64'd1 << GRID_SIZE) - 64'd1);

	// A stalled beat keeps its payload.
	`TBP_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(row_index) && $stable(row_bits) && $stable(last_row), "dump beat changed while stalled")

	// The last flag marks exactly the final row of the grid.
	`TBP_ASSERT_IMPL(a_last, clk, arst_n, out_valid, last_row == (row_index == ROW_LAST), "last_row does not match row_index")

	// Columns outside the grid are never marked.
	`TBP_ASSERT_IMPL(a_cols, clk, arst_n, out_valid, (row_bits & UNUSED_COLS) == 64'd0, "bit set beyond the grid width")

	// After the final row, the next beat, if any, starts a new dump.
	`TBP_ASSERT_NEXT(a_wrap, clk, arst_n, out_valid && out_ready && last_row, !out_valid || row_index == 6'd0, "dump did not restart at row zero")

endmodule

bind turtle_bitmap_plotter tbp_checker #(
	.GRID_SIZE(GRID_SIZE)
) u_tbp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (rows.valid),
	.out_ready (rows.ready),
	.row_index (rows.row_index),
	.row_bits  (rows.row_bits),
	.last_row  (rows.last_row)
);

`default_nettype wire

/* tb/turtle_bitmap_plotter_test.sv */
// Self-checking testbench for the turtle bitmap plotter: commands in, bitmap rows out.
`default_nettype none

module turtle_bitmap_plotter_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tbp_pkg::*;

	localparam int GRID         = 64;
	localparam int RANDOM_ITEMS = 135;
	localparam int TAIL_ITEMS   = 30;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 80;
	localparam int IDLE_LIMIT   = 3000;
	localparam int REPORT_CAP   = 30;

	// Mode codes the block must drop without effect.
	localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

	localparam logic [COORD_W-1:0] EDGE = COORD_W'(GRID - 1);
	localparam logic [COORD_W-1:0] HOME =
		(START_CELL > GRID - 1) ? COORD_W'(GRID - 1) : COORD_W'(START_CELL);

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [STEPS_W-1:0] steps;
		logic               blank;	// dump must return an empty bitmap
	} plot_cmd_t;

	typedef struct packed {
		logic [COORD_W-1:0]    row_index;
		logic [ROW_BITS_W-1:0] row_bits;
		logic                  last_row;
	} row_beat_t;

	logic clk = 1'b0;
	logic arst_n;
	logic blank_flag;
	logic hold_req;
	logic tail;
	int   sender_idle_pct;
	int   mismatches;

	tbp_cmd_if cmd_ch ();
	tbp_row_if row_ch ();

	turtle_bitmap_plotter #(.GRID_SIZE(GRID)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rows   (row_ch)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Model of the plotter state.
	logic [ROW_BITS_W-1:0] canvas [GRID];
	logic [COORD_W-1:0]    turtle_row;
	logic [COORD_W-1:0]    turtle_col;
	heading_t              turtle_heading;
	logic                  pen_is_down;
	row_beat_t             pending_rows [$];

	// Directed commands; the blank dumps are checked against an all-zero bitmap.
	plot_cmd_t directed_cmds [24] = '{
		'{MODE_DUMP,     8'd0,   1'b1},
		'{MODE_SPARE_6,  8'd255, 1'b0},
		'{MODE_SPARE_7,  8'd0,   1'b0},
		'{MODE_MOVE,     8'd255, 1'b0},
		'{MODE_DUMP,     8'd255, 1'b1},
		'{MODE_PEN_DOWN, 8'd255, 1'b0},
		'{MODE_MOVE,     8'd0,   1'b0},
		'{MODE_TURN_R,   8'd0,   1'b0},
		'{MODE_MOVE,     8'd255, 1'b0},
		'{MODE_TURN_R,   8'd255, 1'b0},
		'{MODE_MOVE,     8'd255, 1'b0},
		'{MODE_TURN_R,   8'd0,   1'b0},
		'{MODE_MOVE,     8'd255, 1'b0},
		'{MODE_TURN_L,   8'd0,   1'b0},
		'{MODE_MOVE,     8'd3,   1'b0},
		'{MODE_TURN_L,   8'd255, 1'b0},
		'{MODE_PEN_UP,   8'd255, 1'b0},
		'{MODE_MOVE,     8'd5,   1'b0},
		'{MODE_PEN_DOWN, 8'd0,   1'b0},
		'{MODE_TURN_L,   8'd0,   1'b0},
		'{MODE_MOVE,     8'd7,   1'b0},
		'{MODE_DUMP,     8'd0,   1'b0},
		'{MODE_SPARE_7,  8'd255, 1'b0},
		'{MODE_DUMP,     8'd170, 1'b0}
	};

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		mismatches++;
		if (mismatches <= REPORT_CAP)
			$display("%0t: mismatch in %s: got %0h, want %0h", $realtime, what, got, want);
	endtask

	function automatic void reset_plotter();
		foreach (canvas[r])
			canvas[r] = '0;
		turtle_row     = HOME;
		turtle_col     = HOME;
		turtle_heading = HEAD_RIGHT;
		pen_is_down    = 1'b0;
	endfunction

	function automatic void ink_cell();
		if (pen_is_down)
			canvas[turtle_row][turtle_col] = 1'b1;
	endfunction

	// Applies one accepted command and queues the rows a dump produces.
	function automatic void plot_command(logic [MODE_W-1:0] mode, logic [STEPS_W-1:0] steps,
		logic blank);
		row_beat_t beat;
		int        n;
		case (mode)
			MODE_PEN_UP:   pen_is_down = 1'b0;
			MODE_PEN_DOWN: pen_is_down = 1'b1;
			MODE_TURN_R:   turtle_heading = heading_t'(turtle_heading + 2'd1);
			MODE_TURN_L:   turtle_heading = heading_t'(turtle_heading - 2'd1);
			MODE_MOVE: begin
				// Walk one cell at a time, clamping at the edges.
				for (n = 0; n < int'(steps); n++) begin
					ink_cell();
					case (turtle_heading)
						HEAD_UP:    if (turtle_row > 0) turtle_row--;
						HEAD_RIGHT: if (turtle_col < EDGE) turtle_col++;
						HEAD_DOWN:  if (turtle_row < EDGE) turtle_row++;
						default:    if (turtle_col > 0) turtle_col--;
					endcase
				end
				ink_cell();
			end
			MODE_DUMP: begin
				for (n = 0; n < GRID; n++) begin
					beat.row_index = COORD_W'(n);
					beat.row_bits  = blank ? '0 : canvas[n];
					beat.last_row  = (n == GRID - 1);
					pending_rows.push_back(beat);
				end
			end
			default: ;
		endcase
	endfunction

	// Check each row beat, then update the model with each accepted command.
	always @(posedge clk) begin : check_rows
		row_beat_t want;
		if (arst_n === 1'b1) begin
			if (row_ch.valid && row_ch.ready) begin
				if (pending_rows.size() == 0) begin
					report_mismatch("unexpected row beat", 64'(row_ch.row_index), '0);
				end else begin
					want = pending_rows.pop_front();
					if (row_ch.row_index !== want.row_index)
						report_mismatch("row_index", 64'(row_ch.row_index),
							64'(want.row_index));
					if (row_ch.row_bits !== want.row_bits)
						report_mismatch("row_bits", row_ch.row_bits, want.row_bits);
					if (row_ch.last_row !== want.last_row)
						report_mismatch("last_row", 64'(row_ch.last_row),
							64'(want.last_row));
				end
			end
			if (cmd_ch.valid && cmd_ch.ready)
				plot_command(cmd_ch.mode, cmd_ch.move_steps, blank_flag);
		end
	end

	// Watchdog on cycles in which no beat moves on either channel.
	always @(posedge clk) begin : watchdog
		int idle_cycles;
		if (arst_n === 1'b1) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (row_ch.valid && row_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $realtime, idle_cycles);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Row receiver: random stall bursts, one long hold-off on request, none in the tail.
	initial begin : row_receiver
		int stall_pct;
		int cyc;
		bit hold_done;
		stall_pct      = 25;
		cyc            = 0;
		hold_done      = 1'b0;
		row_ch.ready   = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				row_ch.ready <= 1'b0;
				hold_done = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!tail && $urandom_range(0, 99) < stall_pct) begin
				row_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			row_ch.ready <= 1'b1;
			@(posedge clk);
			cyc++;
			if (cyc % 64 == 0) begin
				case ($urandom_range(0, 2))
					0:       stall_pct = 0;
					1:       stall_pct = 20;
					default: stall_pct = 50;
				endcase
			end
		end
	end

	// Offers one command, with an optional idle burst first, and waits for its beat.
	task automatic offer_cmd(plot_cmd_t item);
		if (!tail && $urandom_range(0, 99) < sender_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.mode       <= item.mode;
		cmd_ch.move_steps <= item.steps;
		blank_flag        <= item.blank;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
	endtask

	initial begin : stimulus
		plot_cmd_t item;
		int        placed;
		int        roll;
		arst_n            = 1'b0;
		cmd_ch.valid      = 1'b0;
		cmd_ch.mode       = MODE_PEN_UP;
		cmd_ch.move_steps = '0;
		blank_flag        = 1'b0;
		hold_req          = 1'b0;
		tail              = 1'b0;
		sender_idle_pct   = 25;
		mismatches        = 0;
		reset_plotter();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_cmds[i])
			offer_cmd(directed_cmds[i]);

		// Long receiver hold-off while a dump and further commands keep coming.
		hold_req <= 1'b1;
		item = '{MODE_DUMP, 8'($urandom_range(0, 255)), 1'b0};
		offer_cmd(item);

		placed = 0;
		while (placed < RANDOM_ITEMS) begin
			roll       = $urandom_range(0, 99);
			item.blank = 1'b0;
			item.steps = 8'($urandom_range(0, 255));
			if (roll < 40) begin
				item.mode  = MODE_MOVE;
				item.steps = 8'($urandom_range(0, 12));
			end else if (roll < 50) begin
				item.mode = MODE_TURN_R;
			end else if (roll < 58) begin
				item.mode = MODE_TURN_L;
			end else if (roll < 72) begin
				item.mode = MODE_PEN_DOWN;
			end else if (roll < 80) begin
				item.mode = MODE_PEN_UP;
			end else if (roll < 88) begin
				item.mode = MODE_DUMP;
			end else if (roll < 94) begin
				item.mode = ($urandom_range(0, 1) != 0) ? MODE_SPARE_6 : MODE_SPARE_7;
			end else begin
				item.mode = MODE_MOVE;
			end
			offer_cmd(item);
			if (item.mode != MODE_SPARE_6 && item.mode != MODE_SPARE_7) begin
				placed++;
				if (placed % 24 == 0) begin
					case ($urandom_range(0, 2))
						0:       sender_idle_pct = 0;
						1:       sender_idle_pct = 15;
						default: sender_idle_pct = 40;
					endcase
				end
			end
			if (placed >= RANDOM_ITEMS - TAIL_ITEMS)
				tail <= 1'b1;
		end
		cmd_ch.valid <= 1'b0;

		// Drain outstanding rows, then let a final move finish.
		@(posedge clk);
		while (pending_rows.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_rows.size() != 0)
			report_mismatch("rows never delivered", 64'(pending_rows.size()), '0);

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire
